[design/rpa_pkg.sv]
// shared types and constants of the register pool allocator
package rpa_pkg;

	// pool size and derived widths
	localparam int NUM_REGS = 20;
	localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int KIND_W   = 2;
	localparam int LIMIT_W  = 5;
	localparam int CNT_W    = 5;
	localparam int GI_W     = 5;
	localparam int MASK_W   = 20;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SPILL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd3;

	// result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// per-register state
	typedef enum logic [1:0] {
		SLOT_FREE = 2'd0,
		SLOT_USED = 2'd1,
		SLOT_RESV = 2'd2
	} slot_t;

	// request payload
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LIMIT_W-1:0] restore_limit;
	} rpa_req_t;

	// result payload
	typedef struct packed {
		logic              status;
		logic [GI_W-1:0]   granted_index;
		logic [CNT_W-1:0]  moved_count;
		logic [MASK_W-1:0] moved_mask;
	} rpa_rsp_t;

	// operation token handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic               up;
		logic [KIND_W-1:0]  kind;
		logic               hit;
		logic [LIMIT_W-1:0] remaining;
		logic [CNT_W-1:0]   count;
		logic [IDX_W-1:0]   index;
		logic [MASK_W-1:0]  mask;
	} rpa_token_t;

endpackage

[design/register_pool_allocator_core.sv]
// register pool allocator top level: token chain over the pool entries
//
// Usage
//   req channel (req_valid/req_ready/req) takes one operation: allocate,
//   free, spill all or restore with a limit. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one result per operation.
//   Each pool entry is a cell; an operation travels as a token through
//   the row of cells, one cell per cycle, upward for allocate and spill,
//   downward for free and restore, each cell updating its own entry.
//   The result register is loaded as the token leaves the far end of the
//   row. One operation is in flight at a time, so the walk through the
//   cell row must end before a new request is taken.
//   req_ready is high when no token is in the row and the result register
//   is empty or being emptied in the same cycle.
//   If the receiver stalls, the result holds in its register and no new
//   request is taken until it is transferred.
//   Reset: all entries free, no token in flight, no result pending.
module register_pool_allocator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rpa_pkg::rpa_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rpa_pkg::rpa_rsp_t rsp
);
	import rpa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t     state_q;
	logic       rsp_valid_q;
	rpa_rsp_t   rsp_q;
	logic       accept;
	logic       go_up;
	rpa_token_t inj;
	rpa_token_t tok    [NUM_REGS];
	rpa_token_t lo_in  [NUM_REGS];
	rpa_token_t hi_in  [NUM_REGS];
	slot_t      slots  [NUM_REGS];
	logic [NUM_REGS-1:0] tok_vld;
	logic [NUM_REGS-1:0] slot_bad;
	logic       exit_up, exit_dn, exit_any;
	rpa_token_t ex;

	// request handshake
	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign go_up     = (req.kind == KIND_ALLOC) || (req.kind == KIND_SPILL);

	// token injected at the end of the row matching its direction
	always_comb begin
		inj           = '0;
		inj.valid     = accept;
		inj.up        = go_up;
		inj.kind      = req.kind;
		inj.remaining = req.restore_limit;
	end

	// row of cells
	for (genvar i = 0; i < NUM_REGS; i++) begin : g_cell
		if (i == 0) begin : g_lo_end
			assign lo_in[i] = (inj.valid && inj.up) ? inj : '0;
		end else begin : g_lo_mid
			assign lo_in[i] = tok[i-1];
		end
		if (i == NUM_REGS - 1) begin : g_hi_end
			assign hi_in[i] = (inj.valid && !inj.up) ? inj : '0;
		end else begin : g_hi_mid
			assign hi_in[i] = tok[i+1];
		end

		rpa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.from_lo (lo_in[i]),
			.from_hi (hi_in[i]),
			.tok     (tok[i]),
			.slot    (slots[i])
		);

		assign tok_vld[i]  = tok[i].valid;
		assign slot_bad[i] = (slots[i] != SLOT_FREE) && (slots[i] != SLOT_USED)
			&& (slots[i] != SLOT_RESV);
	end

	// token leaving the row
	assign exit_up  = tok[NUM_REGS-1].valid && tok[NUM_REGS-1].up;
	assign exit_dn  = tok[0].valid && !tok[0].up;
	assign exit_any = exit_up || exit_dn;
	assign ex       = exit_up ? tok[NUM_REGS-1] : tok[0];

	// control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (exit_any) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exit_any) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exit_any) begin
			rsp_q.status        <= (ex.kind == KIND_ALLOC && !ex.hit) ? STATUS_FULL
				: STATUS_OK;
			rsp_q.granted_index <= GI_W'(ex.index);
			rsp_q.moved_count   <= ex.count;
			rsp_q.moved_mask    <= ex.mask;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// at most one token anywhere in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one token in the cell row");

	// a running operation always has its token in the row
	a_run_has_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ($countones(tok_vld) == 1))
		else $error("running with no token in the row");

	// tokens leave only while an operation runs
	a_exit_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		exit_any |-> (state_q == ST_RUN))
		else $error("token left the row while idle");

	// a result is never overwritten before its transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		exit_any |-> (!rsp_valid_q || rsp_ready))
		else $error("result register overwritten");

	// no entry ever holds the unused state code
	a_slot_code: assert property (@(posedge clk) disable iff (!arst_n)
		slot_bad == '0)
		else $error("pool entry holds an unused state code");

endmodule

[design/rpa_cell.sv]
// one pool entry: holds a register's state and updates the passing token
module rpa_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [rpa_pkg::IDX_W-1:0] idx,
	input  rpa_pkg::rpa_token_t from_lo,
	input  rpa_pkg::rpa_token_t from_hi,
	output rpa_pkg::rpa_token_t tok,
	output rpa_pkg::slot_t      slot
);
	import rpa_pkg::*;

	slot_t      slot_q, slot_d;
	rpa_token_t tok_q, tin, tout;
	logic [MASK_W-1:0] my_bit;

	assign my_bit = MASK_W'(1) << idx;

	// pick the token arriving from the neighbor that points at us
	always_comb begin
		tin = '0;
		priority if (from_lo.valid && from_lo.up) begin
			tin = from_lo;
		end else if (from_hi.valid && !from_hi.up) begin
			tin = from_hi;
		end else begin
			tin = '0;
		end
	end

	// apply the operation to this entry
	always_comb begin
		tout   = tin;
		slot_d = slot_q;
		if (tin.valid) begin
			unique case (tin.kind)
				KIND_ALLOC: begin
					if (!tin.hit && slot_q == SLOT_FREE) begin
						slot_d     = SLOT_USED;
						tout.hit   = 1'b1;
						tout.index = idx;
					end
				end
				KIND_FREE: begin
					if (!tin.hit && slot_q == SLOT_USED) begin
						slot_d   = SLOT_FREE;
						tout.hit = 1'b1;
					end
				end
				KIND_SPILL: begin
					if (slot_q == SLOT_USED) begin
						slot_d     = SLOT_RESV;
						tout.count = tin.count + CNT_W'(1);
						tout.mask  = tin.mask | my_bit;
					end
				end
				KIND_RESTORE: begin
					if (tin.remaining != '0 && slot_q == SLOT_RESV) begin
						slot_d         = SLOT_USED;
						tout.remaining = tin.remaining - LIMIT_W'(1);
						tout.count     = tin.count + CNT_W'(1);
						tout.mask      = tin.mask | my_bit;
					end
				end
				default: begin
					tout = tin;
				end
			endcase
		end
	end

	// entry state and outgoing token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_FREE;
			tok_q  <= '0;
		end else begin
			slot_q <= slot_d;
			tok_q  <= tout;
		end
	end

	assign tok  = tok_q;
	assign slot = slot_q;

endmodule
